// File: design/ptrt_pkg.sv
// Shared constants, codes and types for the periodic task release table.
package ptrt_pkg;
  localparam int unsigned SlotCountDef = 8;
  localparam int unsigned CmdW = 3;
  localparam int unsigned IdW = 8;
  localparam int unsigned PerW = 16;
  localparam int unsigned StW = 2;
  localparam int unsigned GivenW = 6;
  localparam int unsigned MaskW = 8;
  localparam int unsigned CntW = 32;

  localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD    = 3'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CmdW-1:0] CMD_PAUSE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_RESUME = 3'd4;
  localparam logic [CmdW-1:0] CMD_START  = 3'd5;
  localparam logic [CmdW-1:0] CMD_STOP   = 3'd6;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd7;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_SHORT    = 2'd1;
  localparam logic [StW-1:0] ST_FULL     = 2'd2;
  localparam logic [StW-1:0] ST_BAD_SLOT = 2'd3;

  // Request to the serial divider.
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] dividend;
    logic [PerW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CntW-1:0] quot;
    logic [PerW-1:0] rem;
  } div_rsp_t;
endpackage

// File: design/ptrt_if.sv
// Valid/ready channel interfaces for commands, results and configuration.
interface ptrt_cmd_if;
  import ptrt_pkg::*;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [IdW-1:0]  task_id;
  logic [PerW-1:0] task_period;
  modport source(output valid, command, task_id, task_period, input ready);
  modport sink(input valid, command, task_id, task_period, output ready);
endinterface

interface ptrt_rsp_if;
  import ptrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [StW-1:0]    status;
  logic [GivenW-1:0] slot_given;
  logic [MaskW-1:0]  due_mask;
  modport source(output valid, status, slot_given, due_mask, input ready);
  modport sink(input valid, status, slot_given, due_mask, output ready);
endinterface

interface ptrt_cfg_if;
  import ptrt_pkg::*;
  logic            valid;
  logic            ready;
  logic [PerW-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: design/ptrt_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
module ptrt_div
  import ptrt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned StepW = $clog2(CntW + 1);

  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic [CntW-1:0]  quot_q, quot_d;
  logic [PerW:0]    rem_q, rem_d;
  logic [PerW-1:0]  dsr_q, dsr_d;
  logic             done_q, done_d;
  logic [PerW+1:0]  trial;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[CntW-1]} - {2'b00, dsr_q};
      quot_d = {quot_q[CntW-2:0], ~trial[PerW+1]};
      rem_d  = trial[PerW+1] ? {rem_q[PerW-1:0], quot_q[CntW-1]} : trial[PerW:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(CntW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[PerW-1:0];
endmodule

// File: design/ptrt_mem.sv
// Slot period memory with a registered read port and one write port.
module ptrt_mem
  import ptrt_pkg::*;
#(
  parameter int unsigned SlotCount = SlotCountDef,
  localparam int unsigned AW = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [PerW-1:0] rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [PerW-1:0] wdata_i
);
  logic [PerW-1:0] mem_q [SlotCount];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/periodic_task_release_table_unit.sv
// Top level of the periodic task release table.
// One command item is taken at a time and answered with exactly one result item. Table
// commands go straight to the result; an add runs the period through the serial divider
// that turns it into ticks, and a tick while started walks the slots, one memory read and
// one modulo in the serial divider a slot. The slot flags sit in flip-flops that reset and
// clear empty at once; the period memory needs no clearing pass because an unassigned
// slot's period is never used.
module periodic_task_release_table_unit
  import ptrt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input logic     clk_i,
  input logic     rst_ni,
  ptrt_cmd_if.sink   cmd,
  ptrt_rsp_if.source rsp,
  ptrt_cfg_if.sink   cfg
);
  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SW = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADIV = 3'd1;
  localparam logic [2:0] S_TRD  = 3'd2;
  localparam logic [2:0] S_TDIV = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [PerW-1:0]     base_q;
  logic [SLOT_COUNT-1:0] asg_q, asg_d, run_q, run_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                started_q, started_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [StW-1:0]      st_q, st_d;
  logic [GivenW-1:0]   given_q, given_d;
  logic [MaskW-1:0]    mask_q, mask_d;
  logic [PerW-1:0]     per_q, per_d;
  logic                free_found;
  logic [AW-1:0]       free_idx;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [PerW-1:0]     wdata, rdata;
  div_req_t            dreq;
  div_rsp_t            drsp;
  logic                take;

  assign cmd.ready = (state_q == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;
  assign take = cmd.valid && cmd.ready;
  assign rsp.valid  = (state_q == S_OUT);
  assign rsp.status = st_q;
  assign rsp.slot_given = given_q;
  assign rsp.due_mask = mask_q;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!asg_q[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  ptrt_mem #(.SlotCount(SLOT_COUNT)) u_mem (
    .clk_i, .raddr_i(raddr), .rdata_o(rdata),
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata)
  );

  ptrt_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    state_d = state_q;
    asg_d = asg_q;
    run_d = run_q;
    cnt_d = cnt_q;
    started_d = started_q;
    slot_d = slot_q;
    st_d = st_q;
    given_d = given_q;
    mask_d = mask_q;
    per_d = per_q;
    we = 1'b0;
    waddr = free_idx;
    wdata = drsp.quot[PerW-1:0];
    dreq = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          st_d = ST_OK;
          given_d = '0;
          mask_d = '0;
          slot_d = '0;
          state_d = S_OUT;
          case (cmd.command)
            CMD_TICK: begin
              if (started_q) begin
                cnt_d = cnt_q + 1'b1;
                state_d = S_TRD;
              end
            end
            CMD_ADD: begin
              if (cmd.task_period <= base_q) begin
                st_d = ST_SHORT;
              end else if (!free_found) begin
                st_d = ST_FULL;
              end else begin
                dreq.start = 1'b1;
                dreq.dividend = CntW'(cmd.task_period);
                dreq.divisor = (base_q == '0) ? PerW'(1) : base_q;
                given_d = GivenW'(free_idx);
                state_d = S_ADIV;
              end
            end
            CMD_REMOVE, CMD_PAUSE, CMD_RESUME: begin
              if (32'(cmd.task_id) >= SLOT_COUNT) begin
                st_d = ST_BAD_SLOT;
              end else if (cmd.command == CMD_REMOVE) begin
                asg_d[cmd.task_id[AW-1:0]] = 1'b0;
                run_d[cmd.task_id[AW-1:0]] = 1'b0;
              end else begin
                run_d[cmd.task_id[AW-1:0]] = (cmd.command == CMD_RESUME);
              end
            end
            CMD_START: started_d = 1'b1;
            CMD_STOP:  started_d = 1'b0;
            CMD_CLEAR: begin
              asg_d = '0;
              run_d = '0;
              cnt_d = '0;
            end
            default: st_d = ST_OK;
          endcase
        end
      end
      S_ADIV: begin
        waddr = given_q[AW-1:0];
        if (drsp.done) begin
          we = 1'b1;
          asg_d[given_q[AW-1:0]] = 1'b1;
          run_d[given_q[AW-1:0]] = 1'b1;
          state_d = S_OUT;
        end
      end
      S_TRD: begin
        // The period of the current slot was read at the edge that entered this state.
        if (slot_q == SW'(SLOT_COUNT)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_TDIV;
          per_d = rdata;
          dreq.start = 1'b1;
          dreq.dividend = cnt_q;
          dreq.divisor = (rdata == '0) ? PerW'(1) : rdata;
        end
      end
      S_TDIV: begin
        if (drsp.done) begin
          if (asg_q[slot_q[AW-1:0]] && run_q[slot_q[AW-1:0]] && per_q != '0 &&
              drsp.rem == '0 && 32'(slot_q) < MaskW) begin
            mask_d[slot_q[$clog2(MaskW)-1:0]] = 1'b1;
          end
          slot_d = slot_q + 1'b1;
          state_d = S_TRD;
        end
      end
      S_OUT: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // The memory is addressed with the slot that the next cycle works on.
    raddr = slot_d[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q <= PerW'(1);
      asg_q <= '0;
      run_q <= '0;
      cnt_q <= '0;
      started_q <= 1'b0;
      slot_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) base_q <= cfg.data;
      asg_q <= asg_d;
      run_q <= run_d;
      cnt_q <= cnt_d;
      started_q <= started_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    given_q <= given_d;
    mask_q <= mask_d;
    per_q <= per_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("result item dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != ST_OK |-> rsp.due_mask == '0 && rsp.slot_given == '0)
    else $error("error result carries a mask or slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !cmd.ready)
    else $error("second item taken before the result left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADIV && drsp.done |=> asg_q[$past(given_q[AW-1:0])])
    else $error("added slot not marked assigned");
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the periodic task release table: directed and random commands, predicted.
module tb;
  import ptrt_pkg::*;

  localparam int unsigned NumSlots = SlotCountDef;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [StW-1:0]    status;
    logic [GivenW-1:0] slot_given;
    logic [MaskW-1:0]  due_mask;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptrt_cmd_if cmd ();
  ptrt_rsp_if rsp ();
  ptrt_cfg_if cfg ();

  periodic_task_release_table_unit #(.SLOT_COUNT(NumSlots)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd   (cmd.sink),
    .rsp   (rsp.source),
    .cfg   (cfg.sink)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [PerW-1:0] base_q;
  logic            assigned_q [NumSlots];
  logic            running_q  [NumSlots];
  logic [PerW-1:0] period_q   [NumSlots];
  logic [CntW-1:0] ticks_q;
  logic            started_q;

  answer_t answers_due[$];
  int errors = 0;
  int answers_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int idle_pct = 29;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (answer %0d)", what, got, want,
             answers_seen);
    errors++;
  endtask

  function automatic void clear_slots();
    for (int s = 0; s < NumSlots; s++) begin
      assigned_q[s] = 1'b0;
      running_q[s] = 1'b0;
      period_q[s] = 16'd1;
    end
    ticks_q = '0;
  endfunction

  function automatic answer_t predict_answer(input logic [CmdW-1:0] op,
                                             input logic [IdW-1:0] id,
                                             input logic [PerW-1:0] per);
    answer_t a;
    logic [PerW-1:0] div;
    a = '0;
    case (op)
      CMD_TICK: begin
        if (started_q) begin
          ticks_q = ticks_q + 1;
          for (int s = 0; s < NumSlots; s++)
            if (assigned_q[s] && running_q[s] && period_q[s] != 0 &&
                (ticks_q % period_q[s]) == 0 && s < MaskW)
              a.due_mask[s] = 1'b1;
        end
      end
      CMD_ADD: begin
        if (per <= base_q) begin
          a.status = ST_SHORT;
        end else begin
          a.status = ST_FULL;
          div = (base_q == 0) ? 16'd1 : base_q;
          for (int s = 0; s < NumSlots; s++)
            if (!assigned_q[s] && a.status == ST_FULL) begin
              period_q[s] = per / div;
              assigned_q[s] = 1'b1;
              running_q[s] = 1'b1;
              a.status = ST_OK;
              a.slot_given = GivenW'(s);
            end
        end
      end
      CMD_REMOVE, CMD_PAUSE, CMD_RESUME: begin
        if (id >= NumSlots) begin
          a.status = ST_BAD_SLOT;
        end else if (op == CMD_REMOVE) begin
          assigned_q[id] = 1'b0;
          running_q[id] = 1'b0;
          period_q[id] = 16'd1;
        end else begin
          running_q[id] = (op == CMD_RESUME);
        end
      end
      CMD_START: started_q = 1'b1;
      CMD_STOP:  started_q = 1'b0;
      default:   clear_slots();
    endcase
    return a;
  endfunction

  task automatic send_command(input logic [CmdW-1:0] op, input logic [IdW-1:0] id,
                              input logic [PerW-1:0] per);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    cmd.valid <= 1'b1;
    cmd.command <= op;
    cmd.task_id <= id;
    cmd.task_period <= per;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    answers_due.push_back(predict_answer(op, id, per));
    items_sent++;
    cmd.valid <= 1'b0;
    // The block is busy in the cycle after an accepted item, so nothing is lost here.
    @(posedge clk_i);
  endtask

  task automatic drain_answers();
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [PerW-1:0] value);
    drain_answers();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    base_q = value;
  endtask

  // Answer checker and output stall.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.slot_given, rsp.due_mask};
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected answer", 1, 0);
        end else begin
          want = answers_due.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.slot_given != want.slot_given)
            report_mismatch("slot_given", got.slot_given, want.slot_given);
          if (got.due_mask != want.due_mask)
            report_mismatch("due_mask", got.due_mask, want.due_mask);
        end
        answers_seen++;
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk_i) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d quiet cycles", IdleLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_special_cases();
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_ADD, 8'd0, 16'd1);
    send_command(CMD_ADD, 8'd0, 16'd0);
    send_command(CMD_ADD, 8'hFF, 16'd2);
    send_command(CMD_ADD, 8'd0, 16'd3);
    send_command(CMD_ADD, 8'd0, 16'd4);
    send_command(CMD_START, 8'd0, 16'd0);
    repeat (6) send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_PAUSE, 8'd1, 16'd0);
    send_command(CMD_RESUME, 8'd5, 16'd0);
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_REMOVE, 8'd0, 16'd0);
    send_command(CMD_REMOVE, 8'd8, 16'd0);
    send_command(CMD_PAUSE, 8'hFF, 16'd0);
    send_command(CMD_RESUME, 8'd200, 16'd0);
    send_command(CMD_STOP, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_CLEAR, 8'd0, 16'd0);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < NumSlots + 1; k++) send_command(CMD_ADD, 8'd0, 16'hFFFF);
    send_command(CMD_START, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_CLEAR, 8'd0, 16'd0);
  endtask

  task automatic random_phase(input int count);
    logic [CmdW-1:0] op;
    logic [IdW-1:0] id;
    logic [PerW-1:0] per;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45) op = CMD_TICK;
      else if (r < 65) op = CMD_ADD;
      else if (r < 94) op = CmdW'(CMD_REMOVE + $urandom_range(2));
      else op = CmdW'(CMD_START + $urandom_range(2));
      id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NumSlots - 1));
      // Mostly small tick periods so that slots fire often.
      if ($urandom_range(9) == 0) per = 16'($urandom);
      else per = PerW'(base_q * $urandom_range(1, 12) + $urandom_range(3));
      if ($urandom_range(40) == 0) op = CMD_START;
      send_command(op, id, per);
    end
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.command = '0;
    cmd.task_id = '0;
    cmd.task_period = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    base_q = 16'd1;
    started_q = 1'b0;
    clear_slots();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    write_base(16'd0);
    test_special_cases();
    write_base(16'hFFFF);
    test_full_table();
    write_base(16'd1);
    random_phase(300);
    write_base(16'd7);
    idle_pct = 0;
    random_phase(250);
    idle_pct = 29;
    drain_answers();
    write_base(16'd1000);
    random_phase(300);
    write_base(16'd3);
    random_phase(250);

    drain_answers();
    $display("Sent %0d commands over six base periods, including 0 and 65535;", items_sent);
    $display("checked %0d answers with %0d mismatches.", answers_seen, errors);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
design/ptrt_pkg.sv
design/ptrt_if.sv
design/ptrt_div.sv
design/ptrt_mem.sv
design/periodic_task_release_table_unit.sv
tb/tb.sv
